/* src/idt_pkg.sv */
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types and constants of the in-flight delivery tracker.
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int unsigned TABLE_DEPTH   = 32;
  localparam int unsigned CHAIN_SEG     = 8;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_RESEND  = 2'd1,
    OP_ACK     = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_ACK_HIT  = 3'd2,
    ST_ACK_MISS = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_NONE     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] seq_in;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [31:0] seq_out;
    status_e     status;
    logic [5:0]  in_flight;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [31:0] disp;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [31:0] seq;
  } chain_t;

  typedef struct packed {
    logic        search_en;
    logic        is_ack;
    logic [31:0] key;
    logic [31:0] now;
    logic [31:0] timeout;
    logic        store_en;
    logic [31:0] store_seq;
    logic [31:0] store_disp;
    logic        remove_en;
  } cell_ctrl_t;

endpackage

/* src/idt_cell.sv */
// ----------------------------------------------------------------------------
// idt_cell
// One table slot: holds an entry, flags a match, passes the first-hit token
// and shifts down from its neighbor on removal.
// ----------------------------------------------------------------------------
module idt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idt_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_valid_i,
  input  idt_pkg::entry_t     next_i,
  input  idt_pkg::chain_t     chain_i,
  output idt_pkg::chain_t     chain_o,
  output idt_pkg::entry_t     entry_o
);
  import idt_pkg::*;

  logic        valid_q;
  logic [31:0] seq_q;
  logic [31:0] disp_q;
  logic        hit_q;
  logic        hit_d;
  logic [32:0] deadline;
  logic        expired;
  logic        found;
  logic        load_store;

  assign deadline = {1'b0, disp_q} + {1'b0, ctrl_i.timeout};
  assign expired  = deadline < {1'b0, ctrl_i.now};
  assign hit_d    = valid_q && (ctrl_i.is_ack ? (seq_q == ctrl_i.key) : expired);

  assign found         = chain_i.found | hit_q;
  assign chain_o.found = found;
  assign chain_o.seq   = chain_i.found ? chain_i.seq : seq_q;

  assign load_store = ctrl_i.store_en && !valid_q && prev_valid_i;

  assign entry_o.valid = valid_q;
  assign entry_o.seq   = seq_q;
  assign entry_o.disp  = disp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (ctrl_i.search_en) begin
        hit_q <= hit_d;
      end
      if (ctrl_i.remove_en && found) begin
        valid_q <= next_i.valid;
      end else if (load_store) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.remove_en && found) begin
      seq_q  <= next_i.seq;
      disp_q <= next_i.disp;
    end else if (load_store) begin
      seq_q  <= ctrl_i.store_seq;
      disp_q <= ctrl_i.store_disp;
    end
  end

endmodule

/* src/inflight_delivery_tracker.sv */
// ----------------------------------------------------------------------------
// inflight_delivery_tracker
// Sender-side table of unacknowledged deliveries kept in age order.
// ----------------------------------------------------------------------------
// The table is a row of TableDepth cells, oldest entry in cell 0. A send or
// resend is evaluated and its item stored in the first empty cell before the
// next transfer is taken. In an acknowledge or timeout scan every cell flags a
// match at once, then a first-hit token crosses the row in segments of 8 cells
// with a register between segments, and all cells at and above the first hit
// shift down by one. A result waiting on a stalled output holds the block.
module inflight_delivery_tracker #(
  parameter int unsigned TableDepth = idt_pkg::TABLE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  idt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output idt_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i
);
  import idt_pkg::*;

  localparam int unsigned Segs    = (TableDepth + CHAIN_SEG - 1) / CHAIN_SEG;
  localparam int unsigned CntW    = (Segs > 1) ? $clog2(Segs) : 1;
  localparam int unsigned CountW  = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] ScanInit = CntW'(Segs - 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [31:0]         next_seq_q, next_seq_d;
  logic [31:0]         tmo_q;
  in_t                 item_q;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic                load_out;
  logic                accept;
  logic                out_free;
  logic                full;
  logic [31:0]         store_seq;
  logic [CountW+5:0]   flight_ext;
  cell_ctrl_t          ctrl;
  entry_t              ent   [TableDepth];
  chain_t              chain [TableDepth];
  logic [TableDepth-1:0] valid_vec;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = ent[TableDepth-1].valid;
  assign store_seq = (item_q.op == OP_SEND) ? next_seq_q : item_q.seq_in;

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    chain_t chain_in;
    entry_t next_ent;
    logic   prev_valid;

    if (i == 0) begin : g_head
      assign chain_in   = '0;
      assign prev_valid = 1'b1;
    end else if ((i % CHAIN_SEG) == 0) begin : g_seg
      chain_t seg_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          seg_q <= '0;
        end else begin
          seg_q <= chain[i-1];
        end
      end
      assign chain_in   = seg_q;
      assign prev_valid = ent[i-1].valid;
    end else begin : g_mid
      assign chain_in   = chain[i-1];
      assign prev_valid = ent[i-1].valid;
    end

    if (i == TableDepth - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ent[i+1];
    end

    assign valid_vec[i] = ent[i].valid;

    idt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_i       (next_ent),
      .chain_i      (chain_in),
      .chain_o      (chain[i]),
      .entry_o      (ent[i])
    );
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    count_d         = count_q;
    next_seq_d      = next_seq_q;
    load_out        = 1'b0;
    out_d           = out_q;
    ctrl            = '0;
    ctrl.is_ack     = (item_q.op == OP_ACK);
    ctrl.key        = item_q.seq_in;
    ctrl.now        = item_q.now;
    ctrl.timeout    = tmo_q;
    ctrl.store_seq  = store_seq;
    ctrl.store_disp = item_q.now;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (item_q.op == OP_SEND || item_q.op == OP_RESEND) begin
          if (out_free) begin
            load_out      = 1'b1;
            out_d.seq_out = store_seq;
            if (full) begin
              out_d.status = ST_FULL;
            end else begin
              ctrl.store_en = 1'b1;
              count_d       = count_q + CountW'(1);
              out_d.status  = ST_STORED;
              if (item_q.op == OP_SEND) begin
                next_seq_d = next_seq_q + 32'd1;
              end
            end
            state_d = S_IDLE;
          end
        end else begin
          ctrl.search_en = 1'b1;
          cnt_d          = ScanInit;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CntW'(1);
        end else if (out_free) begin
          load_out       = 1'b1;
          ctrl.remove_en = 1'b1;
          if (chain[TableDepth-1].found) begin
            count_d = count_q - CountW'(1);
          end
          if (item_q.op == OP_ACK) begin
            out_d.seq_out = item_q.seq_in;
            out_d.status  = chain[TableDepth-1].found ? ST_ACK_HIT : ST_ACK_MISS;
          end else begin
            out_d.seq_out = chain[TableDepth-1].found ? chain[TableDepth-1].seq : 32'd0;
            out_d.status  = chain[TableDepth-1].found ? ST_EXPIRED : ST_NONE;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    flight_ext      = {6'd0, count_d};
    out_d.in_flight = flight_ext[5:0];
    out_valid_d     = load_out ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      next_seq_q  <= '0;
      tmo_q       <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      next_seq_q  <= next_seq_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("held count disagrees with valid cells");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= TableDepth)
    else $error("held count above table depth");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EVAL)
    else $error("transfer did not start evaluation");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> state_q != S_IDLE)
    else $error("result loaded while idle");
`endif

endmodule

/* tb/sv/idt_checker.sv */
// ----------------------------------------------------------------------------
// idt_checker
// Watches the tracker's channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Each input transfer is applied to a shadow table of in-flight deliveries that
// is held in age order. The result that transfer should produce is queued.
// Each output transfer is compared field by field with the oldest queued result.
// Register writes update the shadow timeout.
`timescale 1ns / 100ps

module idt_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  idt_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  idt_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   replies_waiting_o
);
  import idt_pkg::*;

  logic [31:0] timeout_ticks;
  logic [31:0] next_seq;
  logic [31:0] flight_seq[$];
  logic [31:0] flight_disp[$];
  out_t        replies_due[$];
  int unsigned mismatches;
  out_t        want;

  function automatic out_t track_delivery(input in_t item);
    out_t        r;
    int          hit;
    logic [31:0] s;
    logic [32:0] deadline;
    r.seq_out = '0;
    r.status  = ST_NONE;
    hit       = -1;
    case (item.op)
      OP_SEND, OP_RESEND: begin
        s = (item.op == OP_SEND) ? next_seq : item.seq_in;
        r.seq_out = s;
        if (flight_seq.size() >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          flight_seq  = {flight_seq, s};
          flight_disp = {flight_disp, item.now};
          if (item.op == OP_SEND) next_seq = next_seq + 32'd1;
          r.status = ST_STORED;
        end
      end
      OP_ACK: begin
        r.seq_out = item.seq_in;
        r.status  = ST_ACK_MISS;
        for (int i = 0; i < flight_seq.size(); i++) begin
          if (hit < 0 && flight_seq[i] == item.seq_in) hit = i;
        end
        if (hit >= 0) begin
          flight_seq.delete(hit);
          flight_disp.delete(hit);
          r.status = ST_ACK_HIT;
        end
      end
      default: begin
        for (int i = 0; i < flight_seq.size(); i++) begin
          deadline = {1'b0, flight_disp[i]} + {1'b0, timeout_ticks};
          if (hit < 0 && deadline < {1'b0, item.now}) hit = i;
        end
        if (hit >= 0) begin
          r.seq_out = flight_seq[hit];
          flight_seq.delete(hit);
          flight_disp.delete(hit);
          r.status = ST_EXPIRED;
        end
      end
    endcase
    r.in_flight = 6'(flight_seq.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks = TIMEOUT_RESET;
      next_seq      = '0;
      flight_seq.delete();
      flight_disp.delete();
      replies_due.delete();
      mismatches    = 0;
      mismatch_count_o  <= 0;
      replies_waiting_o <= 0;
    end else begin
      if (cfg_we_i) timeout_ticks = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got %h", $time, out_data_i);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (out_data_i.seq_out !== want.seq_out) begin
            $display("%0t seq_out mismatch: expected %h, got %h",
                     $time, want.seq_out, out_data_i.seq_out);
            mismatches++;
          end
          if (out_data_i.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, out_data_i.status);
            mismatches++;
          end
          if (out_data_i.in_flight !== want.in_flight) begin
            $display("%0t in_flight mismatch: expected %0d, got %0d",
                     $time, want.in_flight, out_data_i.in_flight);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) replies_due = {replies_due, track_delivery(in_data_i)};
      mismatch_count_o  <= mismatches;
      replies_waiting_o <= replies_due.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the in-flight delivery tracker.
// ----------------------------------------------------------------------------
// A directed opening walks through empty-table scans, misses, resends of an
// all-ones sequence, oldest-first acknowledge and expiry, and both timeout
// extremes. Random phases follow, each under its own timeout: mostly plausible
// send/resend/acknowledge/scan traffic on an advancing tick, with some noise.
// One phase fills the table and runs without idling, one holds the output off
// for a long stretch. The checker beside the block does all comparison.
`timescale 1ns / 100ps

module tb;
  import idt_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned PhaseItems    = 75;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int unsigned mismatch_count;
  int unsigned replies_waiting;

  logic        gaps_on;
  logic        hold_tgl;
  logic        hold_seen;
  logic [31:0] now_tick;
  logic [31:0] issued;

  inflight_delivery_tracker u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  idt_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .mismatch_count_o  (mismatch_count),
    .replies_waiting_o (replies_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_t mk(input op_e op, input logic [31:0] seq, input logic [31:0] now);
    in_t item;
    item.op     = op;
    item.seq_in = seq;
    item.now    = now;
    return item;
  endfunction

  function automatic in_t next_delivery_op(input int send_pct);
    in_t item;
    int  r;
    r = $urandom_range(0, 99);
    item.seq_in = $urandom;
    item.now    = now_tick;
    if (r < 5) begin
      item.op  = op_e'(2'($urandom_range(0, 3)));
      item.now = $urandom;
    end else if (r < 5 + send_pct) begin
      item.op = OP_SEND;
      issued  = issued + 32'd1;
    end else if (r < 15 + send_pct) begin
      item.op = OP_RESEND;
      if ($urandom_range(0, 3) != 0) item.seq_in = issued - $urandom_range(1, 20);
    end else if (r < 60 + send_pct / 2) begin
      item.op = OP_ACK;
      if ($urandom_range(0, 7) != 0) item.seq_in = issued - $urandom_range(1, 24);
    end else begin
      item.op = OP_TIMEOUT;
    end
    now_tick = now_tick + $urandom_range(0, 40);
    return item;
  endfunction

  // offer one transfer, hold it until taken
  task automatic drive_item(input in_t item);
    int gap;
    gap = 0;
    if (gaps_on) begin
      while (gap < 20 && $urandom_range(0, 99) < 27) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_waiting != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stall, with one long hold on request
  initial begin
    out_stall = 1'b0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end
      out_stall <= gaps_on && ($urandom_range(0, 99) < 27);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [31:0] phase_timeout [6];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    gaps_on   = 1'b1;
    hold_tgl  = 1'b0;
    now_tick  = '0;
    issued    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_item(mk(OP_TIMEOUT, 32'h0, 32'd0));
    drive_item(mk(OP_ACK,     32'hFFFF_FFFF, 32'd0));
    drive_item(mk(OP_SEND,    32'h0, 32'd0));
    drive_item(mk(OP_SEND,    32'h0, 32'd100));
    drive_item(mk(OP_RESEND,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drive_item(mk(OP_RESEND,  32'h0, 32'd200));
    drive_item(mk(OP_ACK,     32'h0, 32'd300));
    drive_item(mk(OP_ACK,     32'd5, 32'd300));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'd1000));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'd1101));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'hFFFF_FFFF));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'hFFFF_FFFF));
    drive_item(mk(OP_ACK,     32'hFFFF_FFFF, 32'd0));
    write_timeout(32'hFFFF_FFFF);
    drive_item(mk(OP_SEND,    32'h0, 32'd0));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'hFFFF_FFFF));
    write_timeout(32'd0);
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'd0));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'd1));
    drive_item(mk(OP_SEND,    32'hAAAA_AAAA, 32'h5555_5555));
    drive_item(mk(OP_TIMEOUT, 32'h0, 32'h5555_5556));
    issued = 32'd4;

    phase_timeout[0] = $urandom_range(20, 300);
    phase_timeout[1] = 32'd0;
    phase_timeout[2] = 32'hFFFF_FFFF;
    phase_timeout[3] = TIMEOUT_RESET;
    phase_timeout[4] = $urandom;
    phase_timeout[5] = $urandom_range(1, 60);

    for (int p = 0; p < 6; p++) begin
      write_timeout(phase_timeout[p]);
      gaps_on  <= (p != 2);
      now_tick = $urandom;
      if (p == 2) begin
        // fill the table, then overflow it with sends and resends
        for (int i = 0; i < 40; i++) begin
          drive_item(mk(OP_SEND, $urandom, now_tick));
          issued = issued + 32'd1;
        end
        for (int i = 0; i < 4; i++) drive_item(mk(OP_RESEND, $urandom, now_tick));
      end
      if (p == 3) begin
        hold_tgl <= ~hold_tgl;
        for (int i = 0; i < 40; i++) drive_item(next_delivery_op(70));
      end
      for (int i = 0; i < PhaseItems; i++) drive_item(next_delivery_op((p == 2) ? 25 : 35));
    end

    drain();
    if (mismatch_count == 0 && replies_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
